### sv/gzh_pkg.sv
// ----------------------------------------------------------------------------
// gzh_pkg
// shared widths, result kind codes, header constants and the result word type
// of the gzip member header parser
// ----------------------------------------------------------------------------
`default_nettype none

package gzh_pkg;

  localparam int BYTE_W = 8;
  localparam int KIND_W = 3;

  localparam logic [KIND_W-1:0] KIND_DATA        = 3'd0;
  localparam logic [KIND_W-1:0] KIND_ACCEPT      = 3'd1;
  localparam logic [KIND_W-1:0] KIND_TRANSPARENT = 3'd2;
  localparam logic [KIND_W-1:0] KIND_ERROR       = 3'd3;
  localparam logic [KIND_W-1:0] KIND_EMPTY       = 3'd4;

  localparam logic [BYTE_W-1:0] MAGIC1      = 8'h1f;
  localparam logic [BYTE_W-1:0] MAGIC2      = 8'h8b;
  localparam logic [BYTE_W-1:0] METHOD_DEFL = 8'h08;
  localparam logic [BYTE_W-1:0] FLG_RESV    = 8'he0;

  localparam int FLG_HCRC    = 1;
  localparam int FLG_EXTRA   = 2;
  localparam int FLG_NAME    = 3;
  localparam int FLG_COMMENT = 4;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic [KIND_W-1:0] kind;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

### sv/gzh_in_if.sv
// ----------------------------------------------------------------------------
// gzh_in_if
// byte input channel: one stream byte or an end-of-input marker per word
// ----------------------------------------------------------------------------
`default_nettype none

interface gzh_in_if;
  import gzh_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] byte_value;
  logic              end_marker;

  modport source (output valid, output byte_value, output end_marker, input ready);
  modport sink   (input valid, input byte_value, input end_marker, output ready);

endinterface

`default_nettype wire

### sv/gzh_out_if.sv
// ----------------------------------------------------------------------------
// gzh_out_if
// result channel: a data byte or a status kind per word
// ----------------------------------------------------------------------------
`default_nettype none

interface gzh_out_if;
  import gzh_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic [KIND_W-1:0] kind;
  logic              last;

  modport source (output valid, output out_byte, output kind, output last, input ready);
  modport sink   (input valid, input out_byte, input kind, input last, output ready);

endinterface

`default_nettype wire

### sv/gzip_header_parser.sv
// ----------------------------------------------------------------------------
// gzip_header_parser
// walks a gzip member header byte by byte, then passes the data through;
// reports header accepted, transparent start, header error and empty stream
// ----------------------------------------------------------------------------
//  channel   dir  payload                       handshake
//  in_ch     in   byte_value[7:0], end_marker   valid/ready
//  out_ch    out  out_byte[7:0], kind[2:0], last valid/ready
//
//  one byte per clock while the output keeps up; the header walk is one state update
//  per byte and the results land in a four-word output queue
//  a byte gives up to three result words; input is taken while the queue
//  holds at most one word, so a stalled output backs up after two words
//  synchronous active-low reset, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module gzip_header_parser (
  input  wire logic clk,
  input  wire logic rst_n,
  gzh_in_if.sink    in_ch,
  gzh_out_if.source out_ch
);
  import gzh_pkg::*;

  localparam logic [3:0] P_MAGIC1    = 4'd0;
  localparam logic [3:0] P_MAGIC2    = 4'd1;
  localparam logic [3:0] P_METHOD    = 4'd2;
  localparam logic [3:0] P_FLAGS     = 4'd3;
  localparam logic [3:0] P_FLAGS_BAD = 4'd4;
  localparam logic [3:0] P_SKIP6     = 4'd5;
  localparam logic [3:0] P_XLEN_LO   = 4'd6;
  localparam logic [3:0] P_XLEN_HI   = 4'd7;
  localparam logic [3:0] P_EXTRA     = 4'd8;
  localparam logic [3:0] P_NAME      = 4'd9;
  localparam logic [3:0] P_COMMENT   = 4'd10;
  localparam logic [3:0] P_HCRC      = 4'd11;
  localparam logic [3:0] P_DATA      = 4'd12;
  localparam logic [3:0] P_DROP      = 4'd13;

  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [3:0] phase;
    logic       hcrc;
    logic       accept;
  } adv_t;

  // next header section from stage k on: 0 extra, 1 name, 2 comment, 3 crc
  function automatic adv_t advance(input logic [1:0] k, input logic [BYTE_W-1:0] flg);
    adv_t a;
    a = '0;
    if (k == 2'd0 && flg[FLG_EXTRA]) begin
      a.phase = P_XLEN_LO;
    end else if (k <= 2'd1 && flg[FLG_NAME]) begin
      a.phase = P_NAME;
    end else if (k <= 2'd2 && flg[FLG_COMMENT]) begin
      a.phase = P_COMMENT;
    end else if (flg[FLG_HCRC]) begin
      a.phase = P_HCRC;
      a.hcrc  = 1'b1;
    end else begin
      a.phase  = P_DATA;
      a.accept = 1'b1;
    end
    return a;
  endfunction

  logic [3:0]        phase_r, phase_nxt;
  logic [BYTE_W-1:0] flags_r, flags_nxt;
  logic [15:0]       skip_r, skip_nxt;
  logic              ended_r, ended_nxt;
  res_t              q_r   [QDEPTH];
  res_t              q_nxt [QDEPTH];
  res_t              qs    [QDEPTH];
  logic [2:0]        cnt_r, cnt_nxt, cntp;

  res_t              res [3];
  logic [1:0]        n;
  logic              in_fire, pop, eoi;
  logic [BYTE_W-1:0] b;
  logic [15:0]       skip_dec, xlen;
  adv_t              a;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (cnt_r <= 3'd1);
  assign out_ch.valid = (cnt_r != 3'd0);
  assign pop          = out_ch.valid && out_ch.ready;
  assign out_ch.out_byte = q_r[0].out_byte;
  assign out_ch.kind     = q_r[0].kind;
  assign out_ch.last     = q_r[0].last;

  assign b        = in_ch.byte_value;
  assign eoi      = in_ch.end_marker || ended_r;
  assign skip_dec = skip_r - 16'd1;
  assign xlen     = {b, skip_r[7:0]};

  // header walk for the byte on the input
  always_comb begin
    phase_nxt = phase_r;
    flags_nxt = flags_r;
    skip_nxt  = skip_r;
    ended_nxt = ended_r;
    n         = 2'd0;
    a         = '0;
    for (int i = 0; i < 3; i++) begin
      res[i] = '0;
    end
    if (eoi) begin
      ended_nxt = 1'b1;
      case (phase_r)
        P_MAGIC1: begin
          res[0].kind = KIND_EMPTY;
          n = 2'd1;
          phase_nxt = P_DROP;
        end
        P_MAGIC2: begin
          res[0].kind = KIND_TRANSPARENT;
          res[1].kind = KIND_DATA;
          res[1].out_byte = MAGIC1;
          n = 2'd2;
          phase_nxt = P_DATA;
        end
        P_METHOD, P_FLAGS, P_FLAGS_BAD, P_SKIP6, P_XLEN_LO, P_XLEN_HI,
        P_EXTRA, P_NAME, P_COMMENT, P_HCRC: begin
          res[0].kind = KIND_ERROR;
          n = 2'd1;
          phase_nxt = P_DROP;
        end
        default: begin
        end
      endcase
    end else begin
      case (phase_r)
        P_MAGIC1: begin
          if (b == MAGIC1) begin
            phase_nxt = P_MAGIC2;
          end else begin
            res[0].kind = KIND_TRANSPARENT;
            res[1].kind = KIND_DATA;
            res[1].out_byte = b;
            n = 2'd2;
            phase_nxt = P_DATA;
          end
        end
        P_MAGIC2: begin
          if (b == MAGIC2) begin
            phase_nxt = P_METHOD;
          end else begin
            res[0].kind = KIND_TRANSPARENT;
            res[1].kind = KIND_DATA;
            res[1].out_byte = MAGIC1;
            res[2].kind = KIND_DATA;
            res[2].out_byte = b;
            n = 2'd3;
            phase_nxt = P_DATA;
          end
        end
        P_METHOD: begin
          phase_nxt = (b == METHOD_DEFL) ? P_FLAGS : P_FLAGS_BAD;
        end
        P_FLAGS: begin
          flags_nxt = b;
          if ((b & FLG_RESV) != '0) begin
            res[0].kind = KIND_ERROR;
            n = 2'd1;
            phase_nxt = P_DROP;
          end else begin
            skip_nxt = 16'd6;
            phase_nxt = P_SKIP6;
          end
        end
        P_FLAGS_BAD: begin
          flags_nxt = b;
          res[0].kind = KIND_ERROR;
          n = 2'd1;
          phase_nxt = P_DROP;
        end
        P_SKIP6, P_EXTRA, P_HCRC: begin
          skip_nxt = skip_dec;
          if (skip_dec == 16'd0) begin
            a = advance((phase_r == P_SKIP6) ? 2'd0 :
                        (phase_r == P_EXTRA) ? 2'd1 : 2'd3, flags_r);
            if (phase_r == P_HCRC) begin
              a = '{phase: P_DATA, hcrc: 1'b0, accept: 1'b1};
            end
          end
        end
        P_XLEN_LO: begin
          skip_nxt = {8'd0, b};
          phase_nxt = P_XLEN_HI;
        end
        P_XLEN_HI: begin
          skip_nxt = xlen;
          if (xlen == 16'd0) begin
            a = advance(2'd1, flags_r);
          end else begin
            phase_nxt = P_EXTRA;
          end
        end
        P_NAME: begin
          if (b == '0) begin
            a = advance(2'd2, flags_r);
          end
        end
        P_COMMENT: begin
          if (b == '0) begin
            a = advance(2'd3, flags_r);
          end
        end
        P_DATA: begin
          res[0].kind = KIND_DATA;
          res[0].out_byte = b;
          n = 2'd1;
        end
        default: begin
        end
      endcase
      if (a.phase != 4'd0) begin
        phase_nxt = a.phase;
        if (a.hcrc) begin
          skip_nxt = 16'd2;
        end
        if (a.accept) begin
          res[0].kind = KIND_ACCEPT;
          n = 2'd1;
        end
      end
    end
    if (n != 2'd0) begin
      res[n - 2'd1].last = 1'b1;
    end
  end

  // output queue: shift out at the head, append behind the last word
  always_comb begin
    logic [2:0] idx;
    idx  = '0;
    cntp = cnt_r - {2'd0, pop};
    for (int i = 0; i < QDEPTH; i++) begin
      qs[i] = (pop && i < QDEPTH - 1) ? q_r[(i + 1) % QDEPTH] : q_r[i];
    end
    for (int i = 0; i < QDEPTH; i++) begin
      q_nxt[i] = qs[i];
      idx = 3'(i) - cntp;
      if (in_fire && 3'(i) >= cntp && idx < {1'b0, n}) begin
        q_nxt[i] = res[idx[1:0]];
      end
    end
    cnt_nxt = cntp + (in_fire ? {1'b0, n} : 3'd0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= P_MAGIC1;
      flags_r <= '0;
      skip_r  <= '0;
      ended_r <= 1'b0;
      cnt_r   <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (in_fire) begin
        phase_r <= phase_nxt;
        flags_r <= flags_nxt;
        skip_r  <= skip_nxt;
        ended_r <= ended_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < QDEPTH; i++) begin
      q_r[i] <= q_nxt[i];
    end
  end

`ifndef SYNTHESIS
  a_ended_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    ended_r |=> ended_r)
    else $error("end of input flag cleared");

  a_drop_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == P_DROP |=> phase_r == P_DROP)
    else $error("left drop phase");

  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QDEPTH))
    else $error("output queue overflow");

  a_data_one_word: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && phase_r == P_DATA && !eoi |=>
      cnt_r == $past(cnt_r) + 3'd1 - {2'd0, $past(pop)})
    else $error("data byte did not give exactly one word");
`endif

endmodule

`default_nettype wire
